/* design/button_debounce_longpress_repeat_defines.svh */
// Assertion macros shared by the button debouncer design files.
`ifndef BUTTON_DEBOUNCE_LONGPRESS_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_REPEAT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define BDLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define BDLR_NEVER(label, cond, msg) \
    `BDLR_ASSERT(label, !(cond), msg)

`endif

/* design/bdlr_pkg.sv */
// Package with the types and constants of the button debouncer.
`timescale 1ns / 1ps

package bdlr_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int BTN_AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNT_W = $clog2(NUM_BUTTONS + 1);
    localparam int RAW_W = 16;

    localparam logic [3:0] EV_PRESSED = 4'b0001;
    localparam logic [3:0] EV_RELEASED = 4'b0010;
    localparam logic [3:0] EV_LONG = 4'b0100;
    localparam logic [3:0] EV_REPEAT = 4'b1000;

    typedef enum logic [1:0] {
        CMD_SCAN = 2'd0,
        CMD_READ = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_REPEAT_DELAY = 3'd2,
        REG_REPEAT_RATE = 3'd3,
        REG_INVERT = 3'd4,
        REG_ACTIVE = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] last_agree;
        logic [31:0] press_start;
        logic [31:0] last_repeat;
        logic        long_fired;
        logic [3:0]  pending;
    } entry_t;

endpackage

/* design/bdlr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bdlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/button_debounce_longpress_repeat.sv */
// Steps: a scan or clear-all item reads and writes back entries 0 to n - 1 in ST_SWEEP, where n is
// active_buttons capped at NUM_BUTTONS; a read of an active button covers only that entry. An unknown
// command, an inactive read, or a scan or clear-all with n of zero goes straight to ST_FINISH.
// A new item can be accepted in the cycle after the previous result enters the output register, so
// no item is taken while another is still in flight.
// Reset is asynchronous; per-entry valid bits make all button state read as zero.
`timescale 1ns / 1ps

`include "button_debounce_longpress_repeat_defines.svh"

module button_debounce_longpress_repeat
    import bdlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // raw_bits [15:0], time_ms [47:16], button_index [51:48], clear_bits [55:52]
    input  logic [55:0] s_tdata,
    // command [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pressed_mask [15:0], event_flags [19:16], zero padding [23:20]
    output logic [23:0] m_tdata
);

    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;
    logic [15:0] repeat_delay_reg;
    logic [15:0] repeat_rate_reg;
    logic        invert_reg;
    logic [4:0]  active_reg;

    state_t state_reg, state_next;

    logic [1:0]             cmd_reg;
    logic [NUM_BUTTONS-1:0] lvl_vec_reg;
    logic [31:0]            now_reg;
    logic [3:0]             clr_reg;
    logic [BTN_AW-1:0]      base_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       issued_reg;
    logic                   proc_valid_reg;
    logic                   proc_vld_reg;
    logic [BTN_AW-1:0]      proc_addr_reg;
    logic [NUM_BUTTONS-1:0] entry_valid_reg;
    logic [NUM_BUTTONS-1:0] level_reg;
    logic [3:0]             flags_reg;
    logic                   out_valid_reg;
    logic [15:0]            out_mask_reg;
    logic [3:0]             out_flags_reg;

    logic [5:0]             n6;
    logic [CNT_W-1:0]       n_cnt;
    logic                   accept;
    logic                   read_ok;
    logic [CNT_W-1:0]       total_in;
    logic                   issue;
    logic [BTN_AW-1:0]      rd_addr;
    logic                   finish_fire;
    logic                   sweep_done;
    logic [NUM_BUTTONS-1:0] raw_ext;
    logic [NUM_BUTTONS-1:0] mask_full;
    logic [15:0]            mask_out;

    entry_t ram_rdata;
    entry_t cur_e;
    entry_t new_e;
    logic   lvl;
    logic   old_lvl;
    logic   new_lvl;
    logic   agree_ok;
    logic   rose;
    logic   fell;
    logic   long_ok;
    logic   delay_ok;
    logic   rate_ok;
    logic [31:0] agree_diff;
    logic [31:0] held_diff;
    logic [31:0] rep_diff;

    assign n6 = ({1'b0, active_reg} > 6'(NUM_BUTTONS)) ? 6'(NUM_BUTTONS) : {1'b0, active_reg};
    assign n_cnt = CNT_W'(n6);
    assign read_ok = {2'b00, s_tdata[51:48]} < n6;

    always_comb
    begin
        case (cmd_t'(s_tuser))
            CMD_SCAN:  total_in = n_cnt;
            CMD_CLEAR: total_in = n_cnt;
            CMD_READ:  total_in = read_ok ? CNT_W'(1) : '0;
            default:   total_in = '0;
        endcase
    end

    always_comb
    begin
        raw_ext = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (i < RAW_W)
            begin
                raw_ext[i] = s_tdata[i];
            end
        end
        if (invert_reg)
        begin
            raw_ext = ~raw_ext;
        end
    end

    assign issue = (state_reg == ST_SWEEP) && (issued_reg < total_reg);
    assign rd_addr = base_reg + issued_reg[BTN_AW-1:0];
    assign sweep_done = !issue && !proc_valid_reg;
    assign finish_fire = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (total_in != '0) ? ST_SWEEP : ST_FINISH;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SWEEP:  s_tready = 1'b0;
            ST_FINISH: s_tready = 1'b0;
            default:   s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    bdlr_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(NUM_BUTTONS)
    ) u_state_ram (
        .clk  (clk),
        .we   (proc_valid_reg),
        .waddr(proc_addr_reg),
        .wdata(new_e),
        .re   (issue),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    assign cur_e = proc_vld_reg ? ram_rdata : '0;
    assign lvl = lvl_vec_reg[proc_addr_reg];
    assign old_lvl = level_reg[proc_addr_reg];
    assign agree_diff = now_reg - cur_e.last_agree;
    assign held_diff = now_reg - cur_e.press_start;
    assign rep_diff = now_reg - cur_e.last_repeat;
    assign agree_ok = agree_diff >= {16'd0, debounce_reg};
    assign new_lvl = (lvl != old_lvl && agree_ok) ? lvl : old_lvl;
    assign rose = new_lvl && !old_lvl;
    assign fell = !new_lvl && old_lvl;
    assign long_ok = rose ? (long_press_reg == 16'd0) : (held_diff >= {16'd0, long_press_reg});
    assign delay_ok = rose ? (repeat_delay_reg == 16'd0)
                           : (held_diff >= {16'd0, repeat_delay_reg});
    assign rate_ok = rose ? (repeat_rate_reg == 16'd0) : (rep_diff >= {16'd0, repeat_rate_reg});

    always_comb
    begin
        new_e = cur_e;
        case (cmd_t'(cmd_reg))
            CMD_SCAN:
            begin
                if (lvl == old_lvl || agree_ok)
                begin
                    new_e.last_agree = now_reg;
                end
                if (rose)
                begin
                    new_e.pending = new_e.pending | EV_PRESSED;
                    new_e.press_start = now_reg;
                    new_e.long_fired = 1'b0;
                    new_e.last_repeat = now_reg;
                end
                if (fell)
                begin
                    new_e.pending = new_e.pending | EV_RELEASED;
                end
                if (new_lvl)
                begin
                    if (!new_e.long_fired && long_ok)
                    begin
                        new_e.pending = new_e.pending | EV_LONG;
                        new_e.long_fired = 1'b1;
                    end
                    if (delay_ok && rate_ok)
                    begin
                        new_e.pending = new_e.pending | EV_REPEAT;
                        new_e.last_repeat = now_reg;
                    end
                end
            end
            CMD_READ:  new_e.pending = cur_e.pending & ~clr_reg;
            CMD_CLEAR: new_e.pending = 4'd0;
            default:   new_e = cur_e;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            mask_full[i] = level_reg[i] && (i < int'(n6));
        end
        mask_out = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (i < 16)
            begin
                mask_out[i] = mask_full[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= 16'd50;
            long_press_reg <= 16'd1000;
            repeat_delay_reg <= 16'd500;
            repeat_rate_reg <= 16'd100;
            invert_reg <= 1'b1;
            active_reg <= 5'd16;
            state_reg <= ST_IDLE;
            issued_reg <= '0;
            total_reg <= '0;
            proc_valid_reg <= 1'b0;
            entry_valid_reg <= '0;
            level_reg <= '0;
            flags_reg <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                case (reg_index_t'(cfg_index))
                    REG_DEBOUNCE:     debounce_reg <= cfg_data;
                    REG_LONG_PRESS:   long_press_reg <= cfg_data;
                    REG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                    REG_REPEAT_RATE:  repeat_rate_reg <= cfg_data;
                    REG_INVERT:       invert_reg <= cfg_data[0];
                    REG_ACTIVE:       active_reg <= cfg_data[4:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                issued_reg <= '0;
                total_reg <= total_in;
                flags_reg <= 4'd0;
            end
            else if (issue)
            begin
                issued_reg <= issued_reg + CNT_W'(1);
            end
            proc_valid_reg <= issue;
            if (proc_valid_reg)
            begin
                entry_valid_reg[proc_addr_reg] <= 1'b1;
                if (cmd_t'(cmd_reg) == CMD_SCAN)
                begin
                    level_reg[proc_addr_reg] <= new_lvl;
                end
                if (cmd_t'(cmd_reg) == CMD_READ)
                begin
                    flags_reg <= cur_e.pending;
                end
            end
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser;
            lvl_vec_reg <= raw_ext;
            now_reg <= s_tdata[47:16];
            clr_reg <= s_tdata[55:52];
            base_reg <= (cmd_t'(s_tuser) == CMD_READ) ? BTN_AW'(s_tdata[51:48]) : '0;
        end
        if (issue)
        begin
            proc_addr_reg <= rd_addr;
            proc_vld_reg <= entry_valid_reg[rd_addr];
        end
        if (finish_fire)
        begin
            out_mask_reg <= mask_out;
            out_flags_reg <= flags_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'd0, out_flags_reg, out_mask_reg};

    `BDLR_NEVER(a_rmw_no_collide, proc_valid_reg && issue && (proc_addr_reg == rd_addr),
        "write back and read address the same entry")
    `BDLR_ASSERT(a_idle_no_proc, (state_reg == ST_IDLE) |-> !proc_valid_reg,
        "entry still in flight while idle")
    `BDLR_ASSERT(a_issue_bound, (state_reg == ST_SWEEP) |-> (issued_reg <= total_reg),
        "more entries read than the command covers")
    `BDLR_ASSERT(a_result_from_finish, $rose(m_tvalid) |-> $past(state_reg == ST_FINISH),
        "result raised outside the finish step")

endmodule

/* tb/tb_button_debounce_longpress_repeat.sv */
// Testbench for the button debouncer: queued items, a behavioral predictor and a result checker.
`timescale 1ns / 1ps

module tb_button_debounce_longpress_repeat;
    import bdlr_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTED = 10;

    typedef struct {
        logic [1:0]  cmd;
        logic [55:0] data;
    } btn_item_t;

    typedef struct packed {
        logic [3:0]  flags;
        logic [15:0] mask;
    } btn_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    button_debounce_longpress_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the configuration and per-button state.
    logic [15:0] cfg_debounce;
    logic [15:0] cfg_long_press;
    logic [15:0] cfg_repeat_delay;
    logic [15:0] cfg_repeat_rate;
    logic        cfg_invert;
    logic [4:0]  cfg_active;

    logic        btn_level [NUM_BUTTONS];
    logic [31:0] btn_agree [NUM_BUTTONS];
    logic [31:0] btn_press_start [NUM_BUTTONS];
    logic [31:0] btn_last_repeat [NUM_BUTTONS];
    logic        btn_long_fired [NUM_BUTTONS];
    logic [3:0]  btn_pending [NUM_BUTTONS];

    btn_item_t   pending_items [$];
    btn_report_t expected_reports [$];

    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          in_fire_seen = 1'b0;
    bit          out_fire_seen = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    logic [15:0] phys_level = '0;
    logic [31:0] clock_ms = '0;

    function automatic btn_report_t step_debouncer(input logic [1:0] cmd,
            input logic [15:0] raw, input logic [31:0] now, input logic [3:0] idx,
            input logic [3:0] clr);
        btn_report_t report;
        int          n;
        int          b;
        logic [15:0] level_word;
        logic        old;
        logic [31:0] held;
        logic [31:0] since;
        report = '0;
        n = (cfg_active > NUM_BUTTONS) ? NUM_BUTTONS : int'(cfg_active);
        if (cmd == CMD_SCAN)
        begin
            level_word = cfg_invert ? ~raw : raw;
            for (b = 0; b < n; b++)
            begin
                old = btn_level[b];
                since = now - btn_agree[b];
                if (level_word[b] != old)
                begin
                    if (since >= {16'd0, cfg_debounce})
                    begin
                        btn_level[b] = level_word[b];
                        btn_agree[b] = now;
                    end
                end
                else
                begin
                    btn_agree[b] = now;
                end
                if (btn_level[b] != old)
                begin
                    if (btn_level[b])
                    begin
                        btn_pending[b] |= EV_PRESSED;
                        btn_press_start[b] = now;
                        btn_long_fired[b] = 1'b0;
                        btn_last_repeat[b] = now;
                    end
                    else
                    begin
                        btn_pending[b] |= EV_RELEASED;
                    end
                end
                if (btn_level[b])
                begin
                    held = now - btn_press_start[b];
                    since = now - btn_last_repeat[b];
                    if (!btn_long_fired[b] && held >= {16'd0, cfg_long_press})
                    begin
                        btn_pending[b] |= EV_LONG;
                        btn_long_fired[b] = 1'b1;
                    end
                    if (held >= {16'd0, cfg_repeat_delay} && since >= {16'd0, cfg_repeat_rate})
                    begin
                        btn_pending[b] |= EV_REPEAT;
                        btn_last_repeat[b] = now;
                    end
                end
            end
        end
        else if (cmd == CMD_READ)
        begin
            if (int'(idx) < n)
            begin
                report.flags = btn_pending[idx];
                btn_pending[idx] &= ~clr;
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            for (b = 0; b < n; b++)
                btn_pending[b] = '0;
        end
        for (b = 0; b < n; b++)
            report.mask[b] = btn_level[b];
        return report;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic void queue_item(input logic [1:0] cmd, input logic [15:0] raw,
            input logic [31:0] now, input logic [3:0] idx, input logic [3:0] clr);
        btn_item_t item;
        item.cmd = cmd;
        item.data = {clr, idx, now, raw};
        pending_items.push_back(item);
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_register(input reg_index_t index, input logic [15:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_DEBOUNCE:     cfg_debounce = value;
            REG_LONG_PRESS:   cfg_long_press = value;
            REG_REPEAT_DELAY: cfg_repeat_delay = value;
            REG_REPEAT_RATE:  cfg_repeat_rate = value;
            REG_INVERT:       cfg_invert = value[0];
            REG_ACTIVE:       cfg_active = value[4:0];
            default:          ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] deb, input logic [15:0] lp,
            input logic [15:0] rd, input logic [15:0] rr, input logic inv,
            input logic [4:0] act);
        wait_drained();
        write_register(REG_DEBOUNCE, deb);
        write_register(REG_LONG_PRESS, lp);
        write_register(REG_REPEAT_DELAY, rd);
        write_register(REG_REPEAT_RATE, rr);
        write_register(REG_INVERT, {15'd0, inv});
        write_register(REG_ACTIVE, {11'd0, act});
    endtask

    // Scans follow a slowly changing set of held buttons with contact bounce on top.
    task automatic queue_activity(input int count, input int step_max);
        int          k;
        int          pick;
        logic [15:0] raw;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    phys_level ^= 16'(1 << $urandom_range(0, 15));
                if ($urandom_range(0, 49) == 0)
                    phys_level = 16'($urandom);
                raw = phys_level;
                if ($urandom_range(0, 3) == 0)
                    raw ^= 16'($urandom & $urandom);
                if (cfg_invert)
                    raw = ~raw;
                clock_ms += $urandom_range(0, step_max);
                if ($urandom_range(0, 49) == 0)
                    clock_ms = $urandom;
                queue_item(CMD_SCAN, raw, clock_ms, 4'($urandom), 4'($urandom));
            end
            else if (pick < 88)
            begin
                queue_item(CMD_READ, 16'($urandom), $urandom, 4'($urandom), 4'($urandom));
            end
            else if (pick < 95)
            begin
                queue_item(CMD_CLEAR, 16'($urandom), $urandom, 4'($urandom), 4'($urandom));
            end
            else
            begin
                queue_item(CMD_UNKNOWN, 16'($urandom), $urandom, 4'($urandom), 4'($urandom));
            end
        end
    endtask

    always @(negedge clk)
    begin : feed_items
        logic      valid_next;
        btn_item_t next_item;
        valid_next = s_tvalid;
        if (in_fire_seen)
        begin
            in_fire_seen = 1'b0;
            valid_next = 1'b0;
        end
        if (rst_n && !valid_next)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                s_tdata <= next_item.data;
                s_tuser <= next_item.cmd;
                valid_next = 1'b1;
                send_gap = draw_wait(send_calm);
            end
        end
        s_tvalid <= valid_next;
    end

    always @(negedge clk)
    begin : pace_results
        if (out_fire_seen)
        begin
            out_fire_seen = 1'b0;
            recv_stall = draw_wait(recv_calm);
        end
        if (recv_stall != 0)
        begin
            recv_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= rst_n;
        end
    end

    always @(posedge clk)
    begin : watch_ports
        btn_report_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_button_debounce_longpress_repeat: errors");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                out_fire_seen = 1'b1;
                if (expected_reports.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTED)
                        $display("unexpected result: mask %h flags %h",
                                 m_tdata[15:0], m_tdata[19:16]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (m_tdata[15:0] !== want.mask || m_tdata[19:16] !== want.flags)
                    begin
                        if (mismatch_count < MAX_REPORTED)
                            $display("mismatch: expected mask %h flags %h, got mask %h flags %h",
                                     want.mask, want.flags, m_tdata[15:0], m_tdata[19:16]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_fire_seen = 1'b1;
                expected_reports.push_back(step_debouncer(s_tuser, s_tdata[15:0],
                    s_tdata[47:16], s_tdata[51:48], s_tdata[55:52]));
            end
        end
    end

    initial
    begin : run_test
        int          p;
        logic [15:0] deb;
        cfg_debounce = 16'd50;
        cfg_long_press = 16'd1000;
        cfg_repeat_delay = 16'd500;
        cfg_repeat_rate = 16'd100;
        cfg_invert = 1'b1;
        cfg_active = 5'd16;
        for (p = 0; p < NUM_BUTTONS; p++)
        begin
            btn_level[p] = 1'b0;
            btn_agree[p] = '0;
            btn_press_start[p] = '0;
            btn_last_repeat[p] = '0;
            btn_long_fired[p] = 1'b0;
            btn_pending[p] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: debounce, long press, repeat and wrapping time.
        queue_item(CMD_READ, 16'h0000, 32'h0, 4'd0, 4'hF);
        queue_item(CMD_SCAN, 16'hFFFF, 32'd0, 4'd0, 4'd0);
        queue_item(CMD_SCAN, 16'h0000, 32'd0, 4'd0, 4'd0);
        queue_item(CMD_SCAN, 16'h0000, 32'd50, 4'hF, 4'hF);
        queue_item(CMD_SCAN, 16'h0000, 32'd1050, 4'd0, 4'd0);
        queue_item(CMD_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 4'h0);
        queue_item(CMD_READ, 16'h0000, 32'h0, 4'd0, 4'hF);
        queue_item(CMD_READ, 16'h0000, 32'h0, 4'd15, 4'h5);
        queue_item(CMD_CLEAR, 16'h0000, 32'h0, 4'd0, 4'd0);
        queue_item(CMD_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 4'hF);
        queue_item(CMD_SCAN, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 4'd0);
        queue_item(CMD_SCAN, 16'h5555, 32'h0000_0010, 4'd0, 4'd0);
        queue_item(CMD_READ, 16'h0000, 32'h0, 4'd15, 4'hF);

        // Zero delays with a press at time zero.
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 5'd16);
        queue_item(CMD_SCAN, 16'h0001, 32'd0, 4'd0, 4'd0);
        queue_item(CMD_READ, 16'h0000, 32'd0, 4'd0, 4'hF);
        queue_item(CMD_SCAN, 16'h0000, 32'd0, 4'd0, 4'd0);
        queue_item(CMD_READ, 16'h0000, 32'd0, 4'd0, 4'h2);
        queue_item(CMD_SCAN, 16'hFFFF, 32'd5, 4'd0, 4'd0);

        // Largest delays, and an active count beyond the built button count.
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31);
        queue_item(CMD_SCAN, 16'h00FF, 32'd100, 4'd0, 4'd0);
        queue_item(CMD_SCAN, 16'h00FF, 32'd100 + 32'hFFFF, 4'd0, 4'd0);
        queue_item(CMD_SCAN, 16'h00FF, 32'd100 + 32'h1FFFE, 4'd0, 4'd0);
        queue_item(CMD_READ, 16'h0000, 32'd0, 4'd15, 4'hF);
        queue_item(CMD_READ, 16'h0000, 32'd0, 4'd9, 4'h3);
        queue_item(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 4'hF);

        apply_settings(16'd50, 16'd1000, 16'd500, 16'd100, 1'b1, 5'd16);
        queue_activity(150, 120);
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 5'd16);
        queue_activity(100, 3);
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31);
        queue_activity(100, 30000);
        apply_settings(16'd3, 16'd30, 16'd12, 16'd4, 1'b0, 5'd9);
        clock_ms = 32'hFFFF_FF00;
        queue_activity(150, 6);
        apply_settings(16'd10, 16'd20, 16'd10, 16'd5, 1'b1, 5'd0);
        queue_activity(50, 10);
        for (p = 0; p < 4; p++)
        begin
            deb = 16'($urandom_range(0, 40));
            apply_settings(deb, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 100)),
                           16'($urandom_range(0, 30)), 1'($urandom),
                           5'($urandom_range(1, NUM_BUTTONS)));
            queue_activity(110, deb / 4 + 3);
        end

        wait_drained();
        repeat (40) @(posedge clk);
        mismatch_count += expected_reports.size();
        if (mismatch_count == 0)
            $display("tb_button_debounce_longpress_repeat: clean");
        else
            $display("tb_button_debounce_longpress_repeat: errors");
        $finish;
    end

endmodule

/* button_debounce_longpress_repeat.f */
+incdir+design
design/bdlr_pkg.sv
design/bdlr_ram.sv
design/button_debounce_longpress_repeat.sv
tb/tb_button_debounce_longpress_repeat.sv
